// File: rtl/core/ltr_pkg.sv
package ltr_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 17;

  typedef enum logic [CfgIdxW-1:0] {
    REG_MODE        = 3'd0,
    REG_ALPHA       = 3'd1,
    REG_THRESHOLD   = 3'd2,
    REG_HYSTERESIS  = 3'd3,
    REG_DEBOUNCE_MS = 3'd4,
    REG_HOLD_MS     = 3'd5,
    REG_RELEASE_MS  = 3'd6,
    REG_REST_LEVEL  = 3'd7
  } reg_idx_e;

  localparam logic [16:0] AlphaMin = 17'd655;
  localparam logic [16:0] AlphaOne = 17'd65536;

  // Fixed mute threshold of 0.5 in Q7.24, sign-extended to the compare width.
  localparam logic signed [33:0] MuteThreshQ24 = 34'sd8388608;

  localparam logic [2:0]  ModeReset       = 3'd0;
  localparam logic [16:0] AlphaReset      = 17'd19661;
  localparam logic [15:0] ThresholdReset  = 16'hD800;
  localparam logic [14:0] HysteresisReset = 15'd768;
  localparam logic [15:0] DebounceReset   = 16'd50;
  localparam logic [15:0] HoldReset       = 16'd500;
  localparam logic [15:0] ReleaseReset    = 16'd200;
  localparam logic [15:0] RestLevelReset  = 16'hA600;

  localparam int unsigned InDataW  = 56;
  localparam int unsigned OutDataW = 56;

  typedef struct packed {
    logic        enable;
    logic        invert;
    logic        mute;
    logic [16:0] alpha;
    logic [15:0] threshold;
    logic [14:0] hysteresis;
    logic [15:0] debounce_ms;
    logic [15:0] hold_ms;
    logic [15:0] release_ms;
    logic [15:0] rest_level;
  } cfg_t;

  typedef struct packed {
    logic [15:0] level;
    logic [31:0] now_ms;
    logic        linked;
  } item_t;

  typedef struct packed {
    logic [31:0] average;
    logic        is_triggered;
    logic        settled_above;
    logic        settling;
    logic        in_hold;
    logic        in_release;
    logic [31:0] settle_start;
    logic [31:0] hold_start;
    logic [31:0] release_start;
    logic [31:0] last_activation;
  } state_t;

  typedef struct packed {
    logic        triggered;
    logic        fire_on;
    logic        fire_off;
    logic        clear_output;
    logic [15:0] smoothed_level;
    logic [31:0] activation_ms;
  } result_t;

endpackage

// File: rtl/core/level_trigger_hold_release.sv
// Level trigger with smoothing, hysteresis, debounce, hold and release.
//
// Each input transaction on the s_axis channel carries one tick: a signed
// Q7.8 dB level, a millisecond timestamp and a link flag. Each tick yields
// exactly one result transaction on the m_axis channel with the triggered
// flag, the on/off edge flags, the output-clear flag, the smoothed level and
// the latest activation timestamp.
// The input register loads at the edge that accepts a transaction, and the
// update logic fills the result register from it once that register is free
// or being taken, which raises m_axis_tvalid. Throughput is one transaction
// per cycle while the receiver does not stall; the rate rests on the
// combinational average update, whose registered result feeds the next tick.
// When the receiver stalls, the result register holds its transaction and the
// input register takes one more; after that s_axis_tready drops until the
// result is taken. Reset clears both valid flags, restores the register
// defaults and loads the average with the default rest level.
// Configuration writes through cfg_we_i take effect at once and must only be
// issued while no transaction is in flight.
module level_trigger_hold_release (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ltr_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [ltr_pkg::CfgDataW-1:0]   cfg_data_i,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // Fields from bit 0: level[15:0], now_ms[47:16], linked[48], zero fill.
  input  logic [ltr_pkg::InDataW-1:0]    s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // Fields from bit 0: triggered[0], fire_on[1], fire_off[2],
  // clear_output[3], smoothed_level[19:4], activation_ms[51:20], zero fill.
  output logic [ltr_pkg::OutDataW-1:0]   m_axis_tdata
);

  ltr_pkg::cfg_t    cfg;
  ltr_pkg::item_t   item_q;
  ltr_pkg::state_t  st_q;
  ltr_pkg::state_t  st_d;
  ltr_pkg::result_t res_d;
  ltr_pkg::result_t res_q;
  logic             in_valid_q;
  logic             out_valid_q;
  logic             s_accept;
  logic             advance;

  ltr_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  ltr_step u_step (
    .cfg_i    (cfg),
    .item_i   (item_q),
    .state_i  (st_q),
    .state_o  (st_d),
    .result_o (res_d)
  );

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_accept) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      item_q.level  <= s_axis_tdata[15:0];
      item_q.now_ms <= s_axis_tdata[47:16];
      item_q.linked <= s_axis_tdata[48];
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.average         <= {ltr_pkg::RestLevelReset, 16'h0000};
      st_q.is_triggered    <= 1'b0;
      st_q.settled_above   <= 1'b0;
      st_q.settling        <= 1'b0;
      st_q.in_hold         <= 1'b0;
      st_q.in_release      <= 1'b0;
      st_q.settle_start    <= 32'd0;
      st_q.hold_start      <= 32'd0;
      st_q.release_start   <= 32'd0;
      st_q.last_activation <= 32'd0;
    end else if (advance) begin
      st_q <= st_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'h0, res_q.activation_ms, res_q.smoothed_level,
                          res_q.clear_output, res_q.fire_off, res_q.fire_on,
                          res_q.triggered};

  a_hold_release_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(st_q.in_hold && st_q.in_release))
    else $error("Hold and release phases are active together.");

  a_fire_on_sets_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && res_d.fire_on |-> res_d.triggered && !st_q.is_triggered && !res_d.fire_off)
    else $error("An on edge was reported without a rising triggered flag.");

  a_fire_off_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && res_d.fire_off |-> res_d.clear_output && !res_d.triggered)
    else $error("An off edge was reported without clearing the output.");

  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q && res_q.triggered == st_q.is_triggered)
    else $error("A processed transaction did not reach the result register.");

endmodule

// File: rtl/core/ltr_cfg_regs.sv
module ltr_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ltr_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [ltr_pkg::CfgDataW-1:0]  cfg_data_i,
  output ltr_pkg::cfg_t                 cfg_o
);

  logic [2:0]  mode_q;
  logic [16:0] alpha_q;
  logic [15:0] threshold_q;
  logic [14:0] hysteresis_q;
  logic [15:0] debounce_q;
  logic [15:0] hold_q;
  logic [15:0] release_q;
  logic [15:0] rest_q;
  logic [16:0] alpha_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= ltr_pkg::ModeReset;
      alpha_q      <= ltr_pkg::AlphaReset;
      threshold_q  <= ltr_pkg::ThresholdReset;
      hysteresis_q <= ltr_pkg::HysteresisReset;
      debounce_q   <= ltr_pkg::DebounceReset;
      hold_q       <= ltr_pkg::HoldReset;
      release_q    <= ltr_pkg::ReleaseReset;
      rest_q       <= ltr_pkg::RestLevelReset;
    end else if (cfg_we_i) begin
      case (ltr_pkg::reg_idx_e'(cfg_idx_i))
        ltr_pkg::REG_MODE:        mode_q       <= cfg_data_i[2:0];
        ltr_pkg::REG_ALPHA:       alpha_q      <= cfg_data_i[16:0];
        ltr_pkg::REG_THRESHOLD:   threshold_q  <= cfg_data_i[15:0];
        ltr_pkg::REG_HYSTERESIS:  hysteresis_q <= cfg_data_i[14:0];
        ltr_pkg::REG_DEBOUNCE_MS: debounce_q   <= cfg_data_i[15:0];
        ltr_pkg::REG_HOLD_MS:     hold_q       <= cfg_data_i[15:0];
        ltr_pkg::REG_RELEASE_MS:  release_q    <= cfg_data_i[15:0];
        ltr_pkg::REG_REST_LEVEL:  rest_q       <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (alpha_q < ltr_pkg::AlphaMin) begin
      alpha_eff = ltr_pkg::AlphaMin;
    end else if (alpha_q > ltr_pkg::AlphaOne) begin
      alpha_eff = ltr_pkg::AlphaOne;
    end else begin
      alpha_eff = alpha_q;
    end
  end

  assign cfg_o.enable      = mode_q[0];
  assign cfg_o.invert      = mode_q[1];
  assign cfg_o.mute        = mode_q[2];
  assign cfg_o.alpha       = alpha_eff;
  assign cfg_o.threshold   = threshold_q;
  assign cfg_o.hysteresis  = hysteresis_q;
  assign cfg_o.debounce_ms = debounce_q;
  assign cfg_o.hold_ms     = hold_q;
  assign cfg_o.release_ms  = release_q;
  assign cfg_o.rest_level  = rest_q;

endmodule

// File: rtl/core/ltr_smooth.sv
module ltr_smooth (
  input  logic [16:0] alpha_i,
  input  logic [15:0] level_i,
  input  logic [31:0] average_i,
  output logic [31:0] average_o
);

  logic [16:0]        beta;
  logic signed [33:0] p_new;
  logic signed [49:0] p_old;
  logic signed [33:0] p_old_scaled;
  logic signed [33:0] sum;

  // Since the new sample carries a factor of 2^16, the floor of the total
  // equals the new-sample product plus the floored old-average term.
  assign beta         = ltr_pkg::AlphaOne - alpha_i;
  assign p_new        = $signed({1'b0, alpha_i}) * $signed(level_i);
  assign p_old        = $signed({1'b0, beta}) * $signed(average_i);
  assign p_old_scaled = p_old[49:16];
  assign sum          = p_new + p_old_scaled;
  assign average_o    = sum[31:0];

endmodule

// File: rtl/core/ltr_step.sv
module ltr_step (
  input  ltr_pkg::cfg_t    cfg_i,
  input  ltr_pkg::item_t   item_i,
  input  ltr_pkg::state_t  state_i,
  output ltr_pkg::state_t  state_o,
  output ltr_pkg::result_t result_o
);

  logic [31:0]        avg_new;
  logic [31:0]        rest_avg;
  logic signed [17:0] thr_eff;
  logic signed [33:0] eff;
  logic signed [33:0] avg_ext;
  logic               above_raw;
  logic               above;
  logic [31:0]        settle_base;
  logic [31:0]        settle_el;
  logic [31:0]        hold_el;
  logic [31:0]        release_el;
  logic               fire_on;
  logic               fire_off;
  logic               clear;
  ltr_pkg::state_t    st;

  ltr_smooth u_smooth (
    .alpha_i   (cfg_i.alpha),
    .level_i   (item_i.level),
    .average_i (state_i.average),
    .average_o (avg_new)
  );

  assign rest_avg = {cfg_i.rest_level, 16'h0000};

  always_comb begin
    if (state_i.is_triggered) begin
      thr_eff = $signed({{2{cfg_i.threshold[15]}}, cfg_i.threshold})
              - $signed({3'b000, cfg_i.hysteresis});
    end else begin
      thr_eff = $signed({{2{cfg_i.threshold[15]}}, cfg_i.threshold});
    end
  end

  assign eff       = cfg_i.mute ? ltr_pkg::MuteThreshQ24 : $signed({thr_eff, 16'h0000});
  assign avg_ext   = $signed({{2{avg_new[31]}}, avg_new});
  assign above_raw = avg_ext >= eff;
  assign above     = cfg_i.invert ? !above_raw : above_raw;

  assign settle_base = state_i.settling ? state_i.settle_start : item_i.now_ms;
  assign settle_el   = item_i.now_ms - settle_base;
  assign hold_el     = item_i.now_ms - state_i.hold_start;
  assign release_el  = item_i.now_ms - state_i.release_start;

  always_comb begin
    st       = state_i;
    fire_on  = 1'b0;
    fire_off = 1'b0;
    clear    = 1'b0;
    if (!cfg_i.enable) begin
      if (state_i.is_triggered) begin
        st.is_triggered = 1'b0;
        clear           = 1'b1;
      end
      st.average = rest_avg;
    end else if (!item_i.linked) begin
      if (state_i.is_triggered) begin
        st.is_triggered = 1'b0;
        fire_off        = 1'b1;
        clear           = 1'b1;
      end
      st.average       = rest_avg;
      st.settled_above = 1'b0;
      st.settling      = 1'b0;
      st.in_hold       = 1'b0;
      st.in_release    = 1'b0;
      st.settle_start  = 32'd0;
      st.hold_start    = 32'd0;
      st.release_start = 32'd0;
    end else begin
      st.average = avg_new;
      if (above != state_i.settled_above) begin
        st.settling     = 1'b1;
        st.settle_start = settle_base;
        if (settle_el >= {16'h0000, cfg_i.debounce_ms}) begin
          st.settled_above = above;
          st.settling      = 1'b0;
        end
      end else begin
        st.settling = 1'b0;
      end

      if (!state_i.is_triggered) begin
        if (st.settled_above) begin
          st.is_triggered = 1'b1;
          st.in_hold      = 1'b1;
          st.hold_start   = item_i.now_ms;
          st.in_release   = 1'b0;
        end
      end else if (!st.settled_above) begin
        if (state_i.in_hold) begin
          if (hold_el >= {16'h0000, cfg_i.hold_ms}) begin
            st.in_hold       = 1'b0;
            st.in_release    = 1'b1;
            st.release_start = item_i.now_ms;
          end
        end else if (state_i.in_release) begin
          if (release_el >= {16'h0000, cfg_i.release_ms}) begin
            st.is_triggered = 1'b0;
            st.in_release   = 1'b0;
          end
        end
      end else if (state_i.in_release) begin
        st.in_release = 1'b0;
        st.in_hold    = 1'b1;
      end

      if (st.is_triggered && !state_i.is_triggered) begin
        st.last_activation = item_i.now_ms;
        fire_on            = 1'b1;
      end
      if (!st.is_triggered && state_i.is_triggered) begin
        fire_off = 1'b1;
        clear    = 1'b1;
      end
    end
  end

  assign state_o                 = st;
  assign result_o.triggered      = st.is_triggered;
  assign result_o.fire_on        = fire_on;
  assign result_o.fire_off       = fire_off;
  assign result_o.clear_output   = clear;
  assign result_o.smoothed_level = st.average[31:16];
  assign result_o.activation_ms  = st.last_activation;

endmodule
